[hw/rtl/trt_pkg.sv]
// ----------------------------------------------------------------------------
// Touch report tracker package
// Shared types, codes and the coordinate mapping function.
// ----------------------------------------------------------------------------
`default_nettype none

package trt_pkg;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepthDefault = 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SWAP_XY        = 3'd0;
  localparam logic [2:0] CFG_INVERT_X       = 3'd1;
  localparam logic [2:0] CFG_INVERT_Y       = 3'd2;
  localparam logic [2:0] CFG_DISPLAY_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_DISPLAY_HEIGHT = 3'd4;

  // Operation codes on the input. The last one is unassigned and ignored.
  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_RESUME = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Action codes on the output.
  localparam logic [2:0] ACT_SKIPPED     = 3'd0;
  localparam logic [2:0] ACT_STATUS_FAIL = 3'd1;
  localparam logic [2:0] ACT_NOT_READY   = 3'd2;
  localparam logic [2:0] ACT_BAD_COUNT   = 3'd3;
  localparam logic [2:0] ACT_POINT_FAIL  = 3'd4;
  localparam logic [2:0] ACT_REPORT      = 3'd5;
  localparam logic [2:0] ACT_RESUMED     = 3'd6;

  localparam int unsigned ReadyBit     = 7;
  localparam logic [2:0]  MaxContacts  = 3'd5;
  localparam logic [3:0]  ReleasedCode = 4'd6;
  localparam logic [7:0]  StreakMax    = 8'd255;
  localparam logic [7:0]  DisableAt    = 8'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic        status_ok;
    logic [7:0]  status_byte;
    logic        point_ok;
    logic [7:0]  track_id;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] action;
    logic       clear_status;
    logic [7:0] block_byte0;
    logic [7:0] block_byte1;
    logic [7:0] block_byte2;
    logic [7:0] block_byte3;
    logic [7:0] block_byte4;
    logic       changed;
    logic       is_disabled;
  } out_beat_t;

  // Class of an item as decided by the front.
  typedef enum logic [2:0] {
    K_STATUS_FAIL,
    K_NOT_READY,
    K_BAD_COUNT,
    K_POINT_FAIL,
    K_REPORT,
    K_RESUME,
    K_REINIT,
    K_IGNORE
  } kind_e;

  // Classified item, with coordinates already mapped to the display.
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  count;
    logic [7:0]  track_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } item_t;

  // Optional mirror, then clamp to the display size when the size is known.
  function automatic logic [15:0] map_axis(input logic [15:0] v, input logic [15:0] size,
                                           input logic inv);
    logic [15:0] m;
    m = v;
    if (inv && size != 16'd0) begin
      m = (size > v) ? (size - 16'd1 - v) : 16'd0;
    end
    if (size != 16'd0 && m >= size) begin
      m = size - 16'd1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/touch_report_tracker.sv]
// An input beat is written into the queue; the back then pops it and registers the result.
// Throughput: one beat per cycle while the taker keeps accepting result beats.
// The two-entry queue lets input beats keep arriving while a result waits for its taker.
// Reset: asynchronous, active low; the failure streak, flags, stored position, configuration
// and both handshakes are cleared at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Touch report tracker top level
// Tracks the poll results of a capacitive touch controller and packs the
// five-byte advertising block for every event.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_report_tracker import trt_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_beat_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_beat_t        out_data_o
);

  // The front is purely combinational apart from the configuration registers:
  // it decides what kind of event the beat is and maps the contact coordinates
  // to the display (swap, mirror, clamp). None of that depends on the tracking
  // state, so it can be done before the beat enters the queue.
  item_t front_item;
  item_t queue_item;
  logic  queue_full, queue_empty, queue_pop;

  trt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .item_o      (front_item)
  );

  // A beat is accepted whenever the queue has room.
  assign in_ready_o = !queue_full;

  trt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_item)
  );

  // The back owns the failure streak, the disable flag, the touch latch and the
  // last count, id and position. It takes one item per cycle whenever its
  // output register is free or being emptied in the same cycle.
  trt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!queue_empty),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

[hw/rtl/trt_front.sv]
// ----------------------------------------------------------------------------
// Touch report tracker front
// Holds the configuration, classifies each poll and maps its coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_front import trt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire in_beat_t    in_data_i,
  output item_t            item_o
);

  logic        swap_xy_q, invert_x_q, invert_y_q;
  logic [15:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_xy_q  <= 1'b0;
      invert_x_q <= 1'b0;
      invert_y_q <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SWAP_XY:        swap_xy_q  <= cfg_wdata_i[0];
        CFG_INVERT_X:       invert_x_q <= cfg_wdata_i[0];
        CFG_INVERT_Y:       invert_y_q <= cfg_wdata_i[0];
        CFG_DISPLAY_WIDTH:  width_q    <= cfg_wdata_i;
        CFG_DISPLAY_HEIGHT: height_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [3:0]  count_raw;
  logic [15:0] axis_a, axis_b;

  always_comb begin
    count_raw = in_data_i.status_byte[3:0];
    axis_a    = swap_xy_q ? in_data_i.raw_y : in_data_i.raw_x;
    axis_b    = swap_xy_q ? in_data_i.raw_x : in_data_i.raw_y;

    item_o.count    = count_raw[2:0];
    item_o.track_id = in_data_i.track_id;
    item_o.pos_x    = map_axis(axis_a, width_q, invert_x_q);
    item_o.pos_y    = map_axis(axis_b, height_q, invert_y_q);

    case (in_data_i.operation)
      OP_POLL: begin
        if (!in_data_i.status_ok) begin
          item_o.kind = K_STATUS_FAIL;
        end else if (!in_data_i.status_byte[ReadyBit]) begin
          item_o.kind = K_NOT_READY;
        end else if (count_raw > {1'b0, MaxContacts}) begin
          item_o.kind = K_BAD_COUNT;
        end else if (count_raw != 4'd0 && !in_data_i.point_ok) begin
          item_o.kind = K_POINT_FAIL;
        end else begin
          item_o.kind = K_REPORT;
        end
      end
      OP_RESUME: item_o.kind = K_RESUME;
      OP_REINIT: item_o.kind = K_REINIT;
      default:   item_o.kind = K_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/trt_queue.sv]
// ----------------------------------------------------------------------------
// Touch report tracker queue
// Short first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_queue import trt_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/trt_back.sv]
// ----------------------------------------------------------------------------
// Touch report tracker back
// Applies classified items to the tracking state and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_back import trt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output logic       item_pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_beat_t  out_data_o
);

  logic [7:0]  streak_q, streak_d;
  logic        disabled_q, disabled_d;
  logic        latched_q, latched_d;
  logic [2:0]  count_q, count_d;
  logic [15:0] x_q, x_d, y_q, y_d;
  logic [7:0]  id_q, id_d;
  logic        out_valid_q;
  out_beat_t   out_q, out_d;
  logic [7:0]  streak_inc;

  assign item_pop_o  = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign streak_inc  = (streak_q == StreakMax) ? streak_q : streak_q + 8'd1;

  always_comb begin
    streak_d   = streak_q;
    disabled_d = disabled_q;
    latched_d  = latched_q;
    count_d    = count_q;
    x_d        = x_q;
    y_d        = y_q;
    id_d       = id_q;
    out_d      = '0;
    out_d.action = ACT_SKIPPED;

    case (item_i.kind)
      K_STATUS_FAIL: begin
        if (!disabled_q) begin
          streak_d     = streak_inc;
          disabled_d   = (streak_inc >= DisableAt);
          out_d.action = ACT_STATUS_FAIL;
        end
      end
      K_NOT_READY: begin
        if (!disabled_q) begin
          streak_d     = '0;
          out_d.action = ACT_NOT_READY;
        end
      end
      K_BAD_COUNT: begin
        if (!disabled_q) begin
          streak_d           = '0;
          out_d.clear_status = 1'b1;
          out_d.action       = ACT_BAD_COUNT;
        end
      end
      K_POINT_FAIL: begin
        // The good status read clears the streak before the point failure counts.
        if (!disabled_q) begin
          streak_d     = 8'd1;
          out_d.action = ACT_POINT_FAIL;
        end
      end
      K_REPORT: begin
        if (!disabled_q) begin
          streak_d = '0;
          if (item_i.count != 3'd0) begin
            x_d       = item_i.pos_x;
            y_d       = item_i.pos_y;
            id_d      = item_i.track_id;
            latched_d = 1'b1;
          end
          count_d            = item_i.count;
          out_d.changed      = (item_i.count != count_q) ||
                               (item_i.count != 3'd0 &&
                                (x_d != x_q || y_d != y_q || id_d != id_q));
          out_d.clear_status = 1'b1;
          out_d.action       = ACT_REPORT;
        end
      end
      K_RESUME: begin
        if (!disabled_q) begin
          streak_d           = '0;
          latched_d          = 1'b0;
          out_d.clear_status = 1'b1;
          out_d.action       = ACT_RESUMED;
        end
      end
      K_REINIT: begin
        disabled_d         = 1'b0;
        streak_d           = '0;
        latched_d          = 1'b0;
        out_d.clear_status = 1'b1;
        out_d.action       = ACT_RESUMED;
      end
      default: ;
    endcase

    // The advertising block always reflects the state after the item.
    if (count_d != 3'd0 || latched_d) begin
      out_d.block_byte0 = {id_d[3:0], (count_d == 3'd0) ? ReleasedCode : {1'b0, count_d}};
      out_d.block_byte1 = x_d[7:0];
      out_d.block_byte2 = x_d[15:8];
      out_d.block_byte3 = y_d[7:0];
      out_d.block_byte4 = y_d[15:8];
    end
    out_d.is_disabled = disabled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q    <= '0;
      disabled_q  <= 1'b0;
      latched_q   <= 1'b0;
      count_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        streak_q   <= streak_d;
        disabled_q <= disabled_d;
        latched_q  <= latched_d;
        count_q    <= count_d;
        x_q        <= x_d;
        y_q        <= y_d;
        id_q       <= id_d;
      end
      if (item_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/trt_checker.sv]
// ----------------------------------------------------------------------------
// Touch report tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_checker import trt_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_data_o
);

  // A result beat waiting for its taker stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // Nothing is shown in the first cycle after reset is released.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat valid straight out of reset");

  // Only a report can flag a change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.changed |-> out_data_o.action == ACT_REPORT)
    else $error("change flag on a beat that is not a report");

  // The status register is cleared exactly on bad count, report and resume.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.clear_status ==
      (out_data_o.action == ACT_BAD_COUNT || out_data_o.action == ACT_REPORT ||
       out_data_o.action == ACT_RESUMED))
    else $error("clear request does not match the action");

endmodule

bind touch_report_tracker trt_checker u_trt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/touch_report_tracker_tb.sv]
// ----------------------------------------------------------------------------
// Touch report tracker testbench
// Drives poll, resume and reinit beats through the valid/ready input, predicts
// every result beat from a behavioural copy of the tracking state and checks
// each one field by field, under several display and mirroring settings.
// ----------------------------------------------------------------------------
module touch_report_tracker_tb;
  import trt_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned Chunks     = 9;
  localparam int unsigned ChunkBeats = 45;

  // Holds the tracking state of the controller as the block should see it, and
  // the result beats that are still owed by the block, oldest first.
  class touch_report_checker;
    logic        swap_axes;
    logic        mirror_x;
    logic        mirror_y;
    logic [15:0] width;
    logic [15:0] height;

    logic [7:0]  streak;
    logic        disabled;
    logic        latched;
    logic [2:0]  seen_count;
    logic [15:0] last_x;
    logic [15:0] last_y;
    logic [7:0]  last_id;

    out_beat_t   due_reports[$];
    int          mismatches;

    function new();
      swap_axes  = 1'b0;
      mirror_x   = 1'b0;
      mirror_y   = 1'b0;
      width      = '0;
      height     = '0;
      streak     = '0;
      disabled   = 1'b0;
      latched    = 1'b0;
      seen_count = '0;
      last_x     = '0;
      last_y     = '0;
      last_id    = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        CFG_SWAP_XY:        swap_axes = value[0];
        CFG_INVERT_X:       mirror_x  = value[0];
        CFG_INVERT_Y:       mirror_y  = value[0];
        CFG_DISPLAY_WIDTH:  width     = value;
        CFG_DISPLAY_HEIGHT: height    = value;
        default: ;
      endcase
    endfunction

    // A size of zero means the display is unknown: the coordinate passes as is.
    function logic [15:0] fold_axis(logic [15:0] v, logic [15:0] size, logic mirror);
      logic [15:0] r;
      if (size == 16'd0) return v;
      r = v;
      if (mirror) r = (v < size) ? size - 16'd1 - v : 16'd0;
      if (r >= size) r = size - 16'd1;
      return r;
    endfunction

    function void count_failure();
      if (streak < StreakMax) streak = streak + 8'd1;
      if (streak >= DisableAt) disabled = 1'b1;
    endfunction

    function void note_poll(in_beat_t b);
      out_beat_t   e;
      logic [3:0]  n;
      logic [15:0] a;
      logic [15:0] c;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [7:0]  nid;
      e = '0;
      e.action = ACT_SKIPPED;
      case (b.operation)
        OP_POLL: begin
          if (disabled) begin
            e.action = ACT_SKIPPED;
          end else if (!b.status_ok) begin
            count_failure();
            e.action = ACT_STATUS_FAIL;
          end else begin
            streak = '0;
            n = b.status_byte[3:0];
            if (!b.status_byte[ReadyBit]) begin
              e.action = ACT_NOT_READY;
            end else if (n > 4'(MaxContacts)) begin
              e.clear_status = 1'b1;
              e.action = ACT_BAD_COUNT;
            end else if (n != 4'd0 && !b.point_ok) begin
              count_failure();
              e.action = ACT_POINT_FAIL;
            end else begin
              nx  = last_x;
              ny  = last_y;
              nid = last_id;
              if (n != 4'd0) begin
                a   = swap_axes ? b.raw_y : b.raw_x;
                c   = swap_axes ? b.raw_x : b.raw_y;
                nx  = fold_axis(a, width, mirror_x);
                ny  = fold_axis(c, height, mirror_y);
                nid = b.track_id;
                latched = 1'b1;
              end
              e.clear_status = 1'b1;
              e.changed = (n[2:0] != seen_count) ||
                          (n != 4'd0 && (nx != last_x || ny != last_y || nid != last_id));
              seen_count = n[2:0];
              last_x  = nx;
              last_y  = ny;
              last_id = nid;
              e.action = ACT_REPORT;
            end
          end
        end
        OP_RESUME: begin
          if (!disabled) begin
            streak  = '0;
            latched = 1'b0;
            e.clear_status = 1'b1;
            e.action = ACT_RESUMED;
          end
        end
        OP_REINIT: begin
          disabled = 1'b0;
          streak   = '0;
          latched  = 1'b0;
          e.clear_status = 1'b1;
          e.action = ACT_RESUMED;
        end
        default: ;
      endcase

      // The advertising block always reflects the state after the event.
      if (seen_count != 3'd0 || latched) begin
        e.block_byte0 = {last_id[3:0], (seen_count == 3'd0) ? ReleasedCode : {1'b0, seen_count}};
        e.block_byte1 = last_x[7:0];
        e.block_byte2 = last_x[15:8];
        e.block_byte3 = last_y[7:0];
        e.block_byte4 = last_y[15:8];
      end
      e.is_disabled = disabled;
      due_reports.push_back(e);
    endfunction

    function void compare(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_report(out_beat_t got);
      out_beat_t e;
      if (due_reports.size() == 0) begin
        $error("result beat with nothing expected: %0h", got);
        mismatches++;
        return;
      end
      e = due_reports.pop_front();
      compare("action", 8'(e.action), 8'(got.action));
      compare("clear_status", 8'(e.clear_status), 8'(got.clear_status));
      compare("block_byte0", e.block_byte0, got.block_byte0);
      compare("block_byte1", e.block_byte1, got.block_byte1);
      compare("block_byte2", e.block_byte2, got.block_byte2);
      compare("block_byte3", e.block_byte3, got.block_byte3);
      compare("block_byte4", e.block_byte4, got.block_byte4);
      compare("changed", 8'(e.changed), 8'(got.changed));
      compare("is_disabled", 8'(e.is_disabled), 8'(got.is_disabled));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_beat_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_beat_t   out_data_o;

  touch_report_checker tracker;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fault_left;
  in_beat_t    last_sent;

  touch_report_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // A hard ceiling on the run, well beyond the slowest correct run with the
  // receiver stalling most of the time.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver decides its ready at each falling edge, so stalls land on any
  // phase of the block's work.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result beats are taken at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_report(out_data_o);
  end

  // Offers one input beat, with an optional random gap first, and records it
  // with the predictor once the block has taken it.
  task automatic send_beat(in_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_poll(b);
    last_sent = b;
  endtask

  // Stops offering beats and waits until every owed result has come back, then
  // lets the queue and the output register of the back settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.set_reg(idx, value);
  endtask

  // Writes all five registers. The single-bit ones get random upper bits,
  // which the block must ignore.
  task automatic program_cfg(logic swap, logic inv_x, logic inv_y,
                             logic [15:0] w, logic [15:0] h);
    write_reg(CFG_SWAP_XY, {15'($urandom), swap});
    write_reg(CFG_INVERT_X, {15'($urandom), inv_x});
    write_reg(CFG_INVERT_Y, {15'($urandom), inv_y});
    write_reg(CFG_DISPLAY_WIDTH, w);
    write_reg(CFG_DISPLAY_HEIGHT, h);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_beat_t beat(logic [1:0] op, logic sok, logic [7:0] sbyte, logic pok,
                                    logic [7:0] id, logic [15:0] x, logic [15:0] y);
    in_beat_t b;
    b.operation   = op;
    b.status_ok   = sok;
    b.status_byte = sbyte;
    b.point_ok    = pok;
    b.track_id    = id;
    b.raw_x       = x;
    b.raw_y       = y;
    return b;
  endfunction

  // Coordinates cluster at zero, near the display edge and at the top of the
  // range, where the mirror and clamp logic has its corners.
  function automatic logic [15:0] pick_coord(logic [15:0] size);
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(7));
      2: return size + 16'($urandom_range(8)) - 16'd4;
      default: return 16'hFFFF - 16'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 16));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Mostly well-formed polls with a ready status and a sane contact count;
  // the rest are resumes, reinits, ignored operations, not-ready polls, failed
  // reads and bad counts. Bursts of failed status reads drive the block into
  // its disabled state, and reinits bring it back.
  function automatic in_beat_t random_beat();
    in_beat_t    b;
    int unsigned pick;
    b.operation   = OP_POLL;
    b.status_ok   = ($urandom_range(99) < 92);
    b.status_byte = {1'b1, 3'($urandom), 4'($urandom_range(5))};
    b.point_ok    = ($urandom_range(99) < 90);
    b.track_id    = 8'($urandom);
    b.raw_x       = pick_coord(tracker.swap_axes ? tracker.height : tracker.width);
    b.raw_y       = pick_coord(tracker.swap_axes ? tracker.width : tracker.height);
    pick = $urandom_range(99);
    if (pick < 5) begin
      b.operation = OP_RESUME;
    end else if (pick < 12) begin
      b.operation = OP_REINIT;
    end else if (pick < 15) begin
      b.operation = OP_UNUSED;
    end
    if ($urandom_range(99) < 8) b.status_byte[7] = 1'b0;
    if ($urandom_range(99) < 8) b.status_byte[3:0] = 4'($urandom_range(6, 15));
    // Repeat the last contact now and then so that unchanged reports occur.
    if ($urandom_range(99) < 20) begin
      b.track_id = last_sent.track_id;
      b.raw_x    = last_sent.raw_x;
      b.raw_y    = last_sent.raw_y;
    end
    if (fault_left == 0 && $urandom_range(99) < 4) fault_left = $urandom_range(3, 8);
    if (fault_left != 0) begin
      b.operation = OP_POLL;
      b.status_ok = 1'b0;
      fault_left--;
    end
    return b;
  endfunction

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SWAP_XY;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    cycles        = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fault_left    = 0;
    last_sent     = '0;
    tracker       = new();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: unknown display, so coordinates pass straight through.
    program_cfg(1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
    send_beat(beat(OP_POLL, 1'b1, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000)); // not ready
    send_beat(beat(OP_POLL, 1'b1, 8'h80, 1'b1, 8'h11, 16'h1234, 16'h5678)); // empty report
    send_beat(beat(OP_POLL, 1'b1, 8'h81, 1'b1, 8'hFF, 16'hFFFF, 16'h0000)); // first touch
    send_beat(beat(OP_POLL, 1'b1, 8'h81, 1'b1, 8'hFF, 16'hFFFF, 16'h0000)); // no change
    send_beat(beat(OP_POLL, 1'b1, 8'hF5, 1'b1, 8'h00, 16'h0000, 16'hFFFF)); // five contacts
    send_beat(beat(OP_POLL, 1'b1, 8'h86, 1'b1, 8'h22, 16'h0001, 16'h0002)); // count too high
    send_beat(beat(OP_POLL, 1'b1, 8'hFF, 1'b0, 8'h33, 16'h0003, 16'h0004)); // count fifteen
    send_beat(beat(OP_POLL, 1'b1, 8'h83, 1'b0, 8'h44, 16'h0005, 16'h0006)); // point read fails
    send_beat(beat(OP_POLL, 1'b1, 8'h80, 1'b0, 8'h55, 16'h0007, 16'h0008)); // release
    send_beat(beat(OP_RESUME, 1'b1, 8'h80, 1'b1, 8'h00, 16'h0000, 16'h0000));
    // Five failed status reads in a row disable the controller.
    repeat (5) send_beat(beat(OP_POLL, 1'b0, 8'h81, 1'b1, 8'h66, 16'h0009, 16'h000A));
    send_beat(beat(OP_POLL, 1'b1, 8'h81, 1'b1, 8'h77, 16'h000B, 16'h000C)); // skipped
    send_beat(beat(OP_RESUME, 1'b1, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000)); // skipped
    send_beat(beat(OP_UNUSED, 1'b1, 8'h81, 1'b1, 8'h88, 16'h000D, 16'h000E)); // ignored
    send_beat(beat(OP_REINIT, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000));
    repeat (3) send_beat(beat(OP_POLL, 1'b0, 8'h00, 1'b0, 8'h99, 16'h0000, 16'h0000));
    send_beat(beat(OP_POLL, 1'b1, 8'h82, 1'b1, 8'hA5, 16'hBEEF, 16'hCAFE)); // streak cleared
    drain();

    // Random part: each chunk runs under its own setting, the first two at
    // the extremes. The first third has a lazy receiver, the second a lazy
    // sender, and the last runs at full rate on both sides.
    for (int unsigned chunk = 0; chunk < Chunks; chunk++) begin
      case (chunk)
        0: program_cfg(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        1: program_cfg(1'b0, 1'b1, 1'b0, 16'd1, 16'd1);
        default: program_cfg(1'($urandom), 1'($urandom), 1'($urandom), pick_size(),
                             pick_size());
      endcase
      if (chunk < 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 72;
      end else if (chunk < 6) begin
        send_idle_pct = 72;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (ChunkBeats) send_beat(random_beat());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.due_reports.size() != 0) begin
      $error("%0d result beats never arrived", tracker.due_reports.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
